// ===== rtl/yuv_diff_sum_of_squares_macros.svh =====
// Assertion macros for the YUV squared-error accumulator
`ifndef YUV_DIFF_SUM_OF_SQUARES_MACROS_SVH
`define YUV_DIFF_SUM_OF_SQUARES_MACROS_SVH

// property that must hold at every edge outside reset
`define YDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// pre at one edge implies post at the next
`define YDS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/yds_pkg.sv =====
// Package: widths, payload types and YUV matrix coefficients
`default_nettype none

package yds_pkg;

  localparam int COMPONENT_BITS = 12;
  localparam int COEF_FRAC_BITS = 14;
  localparam int LANES          = 3;

  localparam int DIFF_W = COMPONENT_BITS + 1;
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int PROD_W = DIFF_W + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAG_W  = COMPONENT_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int ACC_W  = 63;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  localparam int LANE_Y = 0;
  localparam int LANE_U = 1;
  localparam int LANE_V = 2;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [SQ_W-1:0]          sq_t;

  typedef diff_t [0:2]      diff_vec_t;
  typedef coef_t [0:2]      coef_row_t;
  typedef sq_t [0:LANES-1]  sq_vec_t;

  typedef struct packed {
    logic [COMPONENT_BITS-1:0] ref_red;
    logic [COMPONENT_BITS-1:0] ref_green;
    logic [COMPONENT_BITS-1:0] ref_blue;
    logic [COMPONENT_BITS-1:0] test_red;
    logic [COMPONENT_BITS-1:0] test_green;
    logic [COMPONENT_BITS-1:0] test_blue;
    logic                      last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0] luma_error_sum;
    logic [ACC_W-1:0] chroma_u_error_sum;
    logic [ACC_W-1:0] chroma_v_error_sum;
    logic             sum_saturated;
  } out_item_t;

  // pipeline control seen by the accumulator stage
  typedef struct packed {
    logic adv;
    logic valid;
    logic last;
  } pipe_ctl_t;

  // matrix entry in units of 1e-5 to signed fixed point, ties away from zero
  function automatic coef_t coef_of(input int k);
    longint unsigned m;
    longint unsigned c;
    m = longint'((k < 0) ? -k : k);
    c = ((m << COEF_FRAC_BITS) + 64'd50000) / 64'd100000;
    return (k < 0) ? -coef_t'(c) : coef_t'(c);
  endfunction

  localparam coef_row_t YUV_COEF [LANES] = '{
    '{coef_of(29900),  coef_of(58700),  coef_of(11400)},
    '{coef_of(-14713), coef_of(-28886), coef_of(43600)},
    '{coef_of(61500),  coef_of(-51499), coef_of(-10001)}
  };

endpackage

`default_nettype wire

// ===== rtl/yds_lane.sv =====
// One matrix row: three products, rounded magnitude, square
`default_nettype none

module yds_lane
  import yds_pkg::*;
(
  input  logic      clk,
  input  logic      adv,
  input  diff_vec_t diff,
  input  coef_row_t coef,
  output sq_t       sq
);

  logic signed [PROD_W-1:0] prod_r   [3];
  logic signed [PROD_W-1:0] prod_nxt [3];
  logic signed [SUM_W-1:0]  row_sum;
  logic        [SUM_W-1:0]  abs_sum;
  logic        [SUM_W-1:0]  rnd_sum;
  logic        [MAG_W-1:0]  mag_r;
  logic        [MAG_W-1:0]  mag_nxt;
  sq_t                      sq_r;
  sq_t                      sq_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_nxt[j] = $signed(diff[j]) * $signed(coef[j]);
    end
    row_sum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]);
    abs_sum = row_sum[SUM_W-1] ? -row_sum : row_sum;
    rnd_sum = abs_sum + (SUM_W'(1) << (COEF_FRAC_BITS - 1));
    mag_nxt = rnd_sum[COEF_FRAC_BITS +: MAG_W];
    sq_nxt  = mag_r * mag_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[j] <= prod_nxt[j];
      end
      mag_r <= mag_nxt;
      sq_r  <= sq_nxt;
    end
  end

  assign sq = sq_r;

endmodule

`default_nettype wire

// ===== rtl/yds_merge.sv =====
// Saturating accumulators for Y, U and V and the result register
`default_nettype none
`include "yuv_diff_sum_of_squares_macros.svh"

module yds_merge
  import yds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pipe_ctl_t ctl,
  input  sq_vec_t   sq,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [ACC_W-1:0] acc_r   [LANES];
  logic [ACC_W-1:0] acc_nxt [LANES];
  logic [ACC_W:0]   tot     [LANES];
  logic [LANES-1:0] ovf;
  logic             clip_r;
  logic             clip_nxt;
  logic             out_valid_r;
  out_item_t        out_r;
  logic             take;
  logic             acc_clear;
  logic             out_pinned;

  assign take = ctl.adv && ctl.valid;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      tot[k]     = {1'b0, acc_r[k]} + (ACC_W + 1)'(sq[k]);
      ovf[k]     = tot[k][ACC_W];
      acc_nxt[k] = ovf[k] ? ACC_MAX : tot[k][ACC_W-1:0];
    end
    clip_nxt = clip_r | (|ovf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANES; k++) begin
        acc_r[k] <= '0;
      end
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take && ctl.last) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        if (ctl.last) begin
          for (int k = 0; k < LANES; k++) begin
            acc_r[k] <= '0;
          end
          clip_r <= 1'b0;
        end else begin
          for (int k = 0; k < LANES; k++) begin
            acc_r[k] <= acc_nxt[k];
          end
          clip_r <= clip_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctl.last) begin
      out_r.luma_error_sum     <= acc_nxt[LANE_Y];
      out_r.chroma_u_error_sum <= acc_nxt[LANE_U];
      out_r.chroma_v_error_sum <= acc_nxt[LANE_V];
      out_r.sum_saturated      <= clip_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign acc_clear  = acc_r[LANE_Y] == '0 && acc_r[LANE_U] == '0 &&
                      acc_r[LANE_V] == '0 && !clip_r;
  assign out_pinned = out_r.luma_error_sum == ACC_MAX ||
                      out_r.chroma_u_error_sum == ACC_MAX ||
                      out_r.chroma_v_error_sum == ACC_MAX;

  // a last pixel must never overwrite a result still waiting
  `YDS_ASSERT(a_no_overwrite, !(take && ctl.last && out_valid_r && out_stall), "result overwritten")
  // sums and flag restart from zero after a last pixel
  `YDS_ASSERT_NEXT(a_clear, take && ctl.last, acc_clear, "accumulators not cleared")
  // a new result only follows a last pixel
  `YDS_ASSERT(a_rise_src, $rose(out_valid_r) |-> $past(take && ctl.last), "spurious result")
  // a flagged result has at least one sum pinned at full scale
  `YDS_ASSERT(a_sat_flag, (out_valid_r && out_r.sum_saturated) |-> out_pinned, "flag without clip")

endmodule

`default_nettype wire

// ===== rtl/yuv_diff_sum_of_squares.sv =====
// Top level: YUV squared-error accumulator over one image, three parallel lanes
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_item  (pixel pair, last flag)
//  out_    | output    | out_valid/out_stall| out_item (three sums, clip flag)
//
// One pixel pair per cycle while in_stall is low; difference, product, round,
// square and accumulate registers follow one another, the first loaded at the
// transfer edge, and the result is registered as the last pixel is accumulated.
// rst_n clears sums, flag and stage valids.
// Input stalls only while a last pixel sits at the accumulate stage and the
// previous result is still waiting on out_stall.
`default_nettype none

module yuv_diff_sum_of_squares
  import yds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      adv;
  logic      in_xfer;
  logic      out_valid_w;
  logic [3:0] vld_r;
  logic [3:0] lst_r;
  diff_vec_t diff_r;
  diff_vec_t diff_nxt;
  sq_vec_t   sq_w;
  pipe_ctl_t ctl;

  assign adv      = !(vld_r[3] && lst_r[3] && out_valid_w && out_stall);
  assign in_stall = !adv;
  assign in_xfer  = in_valid && adv;

  assign diff_nxt[0] = $signed({1'b0, in_item.ref_red})   - $signed({1'b0, in_item.test_red});
  assign diff_nxt[1] = $signed({1'b0, in_item.ref_green}) - $signed({1'b0, in_item.test_green});
  assign diff_nxt[2] = $signed({1'b0, in_item.ref_blue})  - $signed({1'b0, in_item.test_blue});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      lst_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_xfer};
      lst_r <= {lst_r[2:0], in_item.last_pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r <= diff_nxt;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    yds_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .diff (diff_r),
      .coef (YUV_COEF[k]),
      .sq   (sq_w[k])
    );
  end

  assign ctl.adv   = adv;
  assign ctl.valid = vld_r[3];
  assign ctl.last  = lst_r[3];

  yds_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sq        (sq_w),
    .out_stall (out_stall),
    .out_valid (out_valid_w),
    .out_item  (out_item)
  );

  assign out_valid = out_valid_w;

endmodule

`default_nettype wire
